[sv/smt_pkg.sv]
// Shared types, codes and constants for the station MAC table.
package smt_pkg;

    // Fixed field widths of the request and result ports.
    localparam int KIND_W          = 2;
    localparam int MAC_W           = 48;
    localparam int IP_W            = 32;
    localparam int TIME_W          = 32;
    localparam int STATUS_W        = 2;
    localparam int SLOT_INDEX_W    = 3;
    localparam int STATION_TOTAL_W = 4;
    localparam int MAX_STATIONS_W  = 4;

    // Default table depth and the reset value of the slot limit register.
    localparam int TABLE_SLOTS_DEFAULT = 8;
    localparam logic [MAX_STATIONS_W-1:0] MAX_STATIONS_RESET = 4'd8;

    // Request operation codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SET_IP = 2'd2
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_ZERO_MAC  = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_UPDATE
    } fsm_t;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] connect_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/smt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module smt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/station_mac_table_top.sv]
// Station MAC table: top level with the search and update sequencer.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. It carries kind (add, delete, set IP), station_mac, ip_address and
// time_now. Each request yields exactly one result on status, slot_index and
// station_total, shown for one cycle while done is high; the receiver cannot
// hold a result off, so it must sample it in that cycle.
// A zero MAC or an unused kind is answered in the next cycle without
// raising busy. Any other request scans the table RAM one slot per cycle,
// pipelined against its registered read data, over min(max_stations,
// TABLE_SLOTS) slots; it ends with done after the update on a hit, or once
// every slot in range is checked. The scan uses the single RAM read port,
// and one request is handled at a time.
// The slot limit is written through max_stations_we and max_stations_wdata;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. Reset empties every slot at once through per-slot
// valid flags, clears the count and sets the limit to eight; no clearing pass.
module station_mac_table_top #(
    parameter int TABLE_SLOTS = smt_pkg::TABLE_SLOTS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  max_stations_we,
    input  logic [smt_pkg::MAX_STATIONS_W-1:0]    max_stations_wdata,
    // Request channel.
    input  logic                                  start,
    output logic                                  busy,
    input  logic [smt_pkg::KIND_W-1:0]            kind,
    input  logic [smt_pkg::MAC_W-1:0]             station_mac,
    input  logic [smt_pkg::IP_W-1:0]              ip_address,
    input  logic [smt_pkg::TIME_W-1:0]            time_now,
    // Result channel.
    output logic                                  done,
    output logic [smt_pkg::STATUS_W-1:0]          status,
    output logic [smt_pkg::SLOT_INDEX_W-1:0]      slot_index,
    output logic [smt_pkg::STATION_TOTAL_W-1:0]   station_total
);

    import smt_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    // Sequencer and request registers.
    fsm_t                  state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    entry_t                held_reg, held_next;
    kind_t                 kind_reg, kind_next;
    logic [MAC_W-1:0]      mac_reg, mac_next;
    logic [IP_W-1:0]       ip_reg, ip_next;
    logic [TIME_W-1:0]     time_reg, time_next;

    // Table control state.
    logic [TABLE_SLOTS-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [MAX_STATIONS_W-1:0] max_stations_reg;

    // Result registers.
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic [IDX_W-1:0]      slot_out_reg, slot_out_next;
    logic [CNT_W-1:0]      total_reg, total_next;

    // RAM interface.
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    entry_t                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    logic [CNT_W-1:0]      limit;
    logic                  entry_hit;

    smt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Slots searched: the configured limit, capped at the table depth.
    always_comb
    begin
        if (32'(max_stations_reg) > 32'(TABLE_SLOTS))
        begin
            limit = CNT_W'(TABLE_SLOTS);
        end
        else
        begin
            limit = CNT_W'(max_stations_reg);
        end
    end

    // An add looks for an empty slot; delete and set IP look for the MAC.
    always_comb
    begin
        if (kind_reg == KIND_ADD)
        begin
            entry_hit = !valid_reg[cmp_idx_reg];
        end
        else
        begin
            entry_hit = valid_reg[cmp_idx_reg] && (rd_entry.mac == mac_reg);
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_stations_reg <= MAX_STATIONS_RESET;
        end
        else if (max_stations_we)
        begin
            max_stations_reg <= max_stations_wdata;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cmp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        held_reg     <= held_next;
        kind_reg     <= kind_next;
        mac_reg      <= mac_next;
        ip_reg       <= ip_next;
        time_reg     <= time_next;
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        total_reg    <= total_next;
    end

    // Next state, table updates and results.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        kind_next      = kind_reg;
        mac_next       = mac_reg;
        ip_next        = ip_reg;
        time_next      = time_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        slot_out_next  = slot_out_reg;
        total_next     = total_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind_t'(kind);
                    mac_next  = station_mac;
                    ip_next   = ip_address;
                    time_next = time_now;
                    idx_next  = '0;
                    if (station_mac == '0)
                    begin
                        done_next     = 1'b1;
                        status_next   = STAT_ZERO_MAC;
                        slot_out_next = '0;
                        total_next    = count_reg;
                    end
                    else if ((kind == KIND_ADD) || (kind == KIND_DELETE) ||
                             (kind == KIND_SET_IP))
                    begin
                        state_next = FSM_SCAN;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        status_next   = STAT_NOT_FOUND;
                        slot_out_next = '0;
                        total_next    = count_reg;
                    end
                end
            end

            FSM_SCAN:
            begin
                if (cmp_valid_reg && entry_hit)
                begin
                    // Hit on the slot whose data just came out of the RAM.
                    slot_next  = cmp_idx_reg;
                    held_next  = rd_entry;
                    state_next = FSM_UPDATE;
                end
                else if (idx_reg < limit)
                begin
                    // Issue the next slot read.
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[IDX_W-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end
                else
                begin
                    // Every slot in range checked without a hit.
                    done_next     = 1'b1;
                    status_next   = (kind_reg == KIND_ADD) ? STAT_FULL : STAT_NOT_FOUND;
                    slot_out_next = '0;
                    total_next    = count_reg;
                    state_next    = FSM_IDLE;
                end
            end

            FSM_UPDATE:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_reg;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        ram_wdata.mac          = mac_reg;
                        ram_wdata.connect_time = time_reg;
                        valid_next[slot_reg]   = 1'b1;
                        count_next             = count_reg + CNT_W'(1);
                    end
                    KIND_DELETE:
                    begin
                        valid_next[slot_reg] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        ram_wdata.mac          = held_reg.mac;
                        ram_wdata.ip           = ip_reg;
                        ram_wdata.connect_time = held_reg.connect_time;
                    end
                endcase
                done_next     = 1'b1;
                status_next   = STAT_DONE;
                slot_out_next = slot_reg;
                total_next    = count_next;
                state_next    = FSM_IDLE;
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Ports.
    assign busy          = (state_reg != FSM_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign slot_index    = SLOT_INDEX_W'(slot_out_reg);
    assign station_total = STATION_TOTAL_W'(total_reg);

endmodule

[sv/smt_checker.sv]
// Port-level checker for the station MAC table, bound to the top level.
module smt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [smt_pkg::KIND_W-1:0]          kind,
    input logic [smt_pkg::MAC_W-1:0]           station_mac,
    input logic                                done,
    input logic [smt_pkg::STATUS_W-1:0]        status,
    input logic [smt_pkg::SLOT_INDEX_W-1:0]    slot_index
);

    import smt_pkg::*;

    // A zero MAC is answered in the next cycle with the reject status.
    a_zero_mac_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (station_mac == '0))
        |=> (done && (status == STAT_ZERO_MAC) && (slot_index == '0)))
        else $error("zero MAC request not rejected in the next cycle");

    // A failed request reports slot zero.
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_DONE)) |-> (slot_index == '0))
        else $error("failed request reported a nonzero slot");

    // A result is only shown once the sequencer is back at rest.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still being processed");

    // A valid table request starts a table scan.
    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (station_mac != '0) &&
         ((kind == KIND_ADD) || (kind == KIND_DELETE) || (kind == KIND_SET_IP)))
        |=> (busy && !done))
        else $error("table request did not start a scan");

endmodule

bind station_mac_table_top smt_checker u_smt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .station_mac (station_mac),
    .done        (done),
    .status      (status),
    .slot_index  (slot_index)
);

[test/station_mac_table_top_test.sv]
// Self-checking testbench for the station MAC table top level.
module station_mac_table_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import smt_pkg::*;

    localparam int SLOTS = TABLE_SLOTS_DEFAULT;
    localparam int MAC_POOL_SIZE = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SHOWN_ERRORS = 10;
    // Operation code the block does not define; with a nonzero MAC it must be answered as not found.
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    // One expected answer from the table.
    typedef struct {
        status_t                     status;
        logic [SLOT_INDEX_W-1:0]     slot;
        logic [STATION_TOTAL_W-1:0]  total;
    } station_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         max_stations_we;
    logic [MAX_STATIONS_W-1:0]    max_stations_wdata;
    logic                         start;
    logic                         busy;
    logic [KIND_W-1:0]            req_kind;
    logic [MAC_W-1:0]             req_mac;
    logic [IP_W-1:0]              req_ip;
    logic [TIME_W-1:0]            req_time;
    logic                         done;
    logic [STATUS_W-1:0]          status;
    logic [SLOT_INDEX_W-1:0]      slot_index;
    logic [STATION_TOTAL_W-1:0]   station_total;

    // Shadow copy of the table contents, count and slot limit.
    logic [MAC_W-1:0]             shadow_mac [SLOTS];
    logic [STATION_TOTAL_W-1:0]   shadow_count;
    logic [MAX_STATIONS_W-1:0]    shadow_limit;

    logic [MAC_W-1:0]             mac_pool [MAC_POOL_SIZE];
    station_result_t              pending_results [$];
    int                           error_count;
    int                           idle_cycles;

    station_mac_table_top u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .max_stations_we    (max_stations_we),
        .max_stations_wdata (max_stations_wdata),
        .start              (start),
        .busy               (busy),
        .kind               (req_kind),
        .station_mac        (req_mac),
        .ip_address         (req_ip),
        .time_now           (req_time),
        .done               (done),
        .status             (status),
        .slot_index         (slot_index),
        .station_total      (station_total)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count a failure and show the first few of them.
    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN_ERRORS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // Apply one request to the shadow table and return the answer it must give.
    function automatic station_result_t apply_station_op(input logic [KIND_W-1:0] op,
                                                         input logic [MAC_W-1:0] mac);
        station_result_t res;
        int              scan_len;
        int              hit;
        res.status = STAT_NOT_FOUND;
        res.slot   = '0;
        scan_len   = (shadow_limit > SLOTS) ? SLOTS : int'(shadow_limit);
        hit        = -1;
        if (mac == '0)
        begin
            res.status = STAT_ZERO_MAC;
        end
        else if (op == KIND_ADD)
        begin
            for (int i = 0; i < scan_len; i++)
            begin
                if (hit < 0 && shadow_mac[i] == '0)
                    hit = i;
            end
            if (hit >= 0)
            begin
                shadow_mac[hit] = mac;
                shadow_count    = shadow_count + 1'b1;
                res.status      = STAT_DONE;
                res.slot        = hit[SLOT_INDEX_W-1:0];
            end
            else
            begin
                res.status = STAT_FULL;
            end
        end
        else if (op == KIND_DELETE || op == KIND_SET_IP)
        begin
            for (int i = 0; i < scan_len; i++)
            begin
                if (hit < 0 && shadow_mac[i] == mac)
                    hit = i;
            end
            if (hit >= 0)
            begin
                // The stored IP and connect time are not visible at the ports.
                if (op == KIND_DELETE)
                begin
                    shadow_mac[hit] = '0;
                    if (shadow_count != 0)
                        shadow_count = shadow_count - 1'b1;
                end
                res.status = STAT_DONE;
                res.slot   = hit[SLOT_INDEX_W-1:0];
            end
        end
        res.total = shadow_count;
        return res;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [KIND_W-1:0] op, input logic [MAC_W-1:0] mac,
                                input logic [IP_W-1:0] ip, input logic [TIME_W-1:0] now);
        @(negedge clk);
        start    <= 1'b1;
        req_kind <= op;
        req_mac  <= mac;
        req_ip   <= ip;
        req_time <= now;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_station_op(op, mac));
    endtask

    // Keep start low for a number of cycles.
    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stop sending, wait for every answer, then write the slot limit.
    task automatic write_slot_limit(input logic [MAX_STATIONS_W-1:0] value);
        hold_off(4);
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        max_stations_we    <= 1'b1;
        max_stations_wdata <= value;
        @(negedge clk);
        max_stations_we    <= 1'b0;
        shadow_limit = value;
    endtask

    // Check each answer against the oldest expected one.
    always @(posedge clk)
    begin
        station_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                note_error($sformatf("unexpected result status=%0d slot=%0d total=%0d",
                                     status, slot_index, station_total));
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || slot_index !== want.slot
                    || station_total !== want.total)
                begin
                    note_error($sformatf(
                        "expected status=%0d slot=%0d total=%0d, got %0d %0d %0d",
                        want.status, want.slot, want.total,
                        status, slot_index, station_total));
                end
            end
        end
    end

    // End the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Zero MACs for every operation, the undefined operation code, and delete and set IP of an absent MAC.
    task automatic test_rejected_requests();
        send_request(KIND_ADD, '0, '1, '1);
        send_request(KIND_DELETE, '0, '0, '0);
        send_request(KIND_SET_IP, '0, '1, '0);
        send_request(KIND_RESERVED, '0, '0, '1);
        send_request(KIND_RESERVED, '1, '1, '1);
        send_request(KIND_DELETE, '1, '0, '0);
        send_request(KIND_SET_IP, '1, '1, '1);
    endtask

    // Duplicates, set IP, delete, then fill the table until it is full, add once more and delete a station.
    task automatic test_table_fill();
        logic [MAC_W-1:0] mac;
        send_request(KIND_ADD, '1, '0, '1);
        send_request(KIND_ADD, 48'h1, '1, '0);
        send_request(KIND_ADD, '1, '0, 32'h8000_0001);
        send_request(KIND_SET_IP, '1, '1, '0);
        send_request(KIND_SET_IP, 48'h1, '0, '1);
        send_request(KIND_DELETE, '1, '0, '0);
        send_request(KIND_DELETE, '1, '0, '0);
        for (int i = 0; i < SLOTS - 1; i++)
        begin
            mac = (i % 2 == 0) ? 48'h5555_5555_5555 + i : 48'hAAAA_AAAA_AAAA - i;
            send_request(KIND_ADD, mac, $urandom, $urandom);
        end
        send_request(KIND_ADD, 48'h8000_0000_0000, '0, '0);
        send_request(KIND_DELETE, 48'h1, '0, '0);
    endtask

    // Random traffic: mostly known stations, with some noise, in bursts.
    task automatic run_traffic(input int count, input bit with_gaps);
        logic [KIND_W-1:0] op;
        logic [MAC_W-1:0]  mac;
        int                roll;
        int                burst_left;
        for (int i = 0; i < MAC_POOL_SIZE; i++)
            mac_pool[i] = random_mac();
        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 36)
                op = KIND_ADD;
            else if (roll < 66)
                op = KIND_DELETE;
            else if (roll < 93)
                op = KIND_SET_IP;
            else
                op = KIND_RESERVED;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                mac = '0;
            else if (roll < 10)
                mac = random_mac();
            else if (roll < 55 && shadow_mac[$urandom_range(0, SLOTS - 1)] != '0)
                mac = shadow_mac[$urandom_range(0, SLOTS - 1)];
            else
                mac = mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
            // A pick of an empty slot above may read zero; that is a valid case too.
            send_request(op, mac, $urandom, $urandom);
            burst_left--;
            if (burst_left == 0)
            begin
                if (with_gaps)
                    hold_off($urandom_range(1, 20));
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Walk the slot limit through small, zero, oversized and default values.
    task automatic test_slot_limit_sweep();
        logic [MAX_STATIONS_W-1:0] limit_settings [9];
        limit_settings = '{4'd3, 4'd0, 4'd1, 4'd15, 4'd9, 4'd5, 4'd2, 4'd12, 4'd8};
        foreach (limit_settings[i])
        begin
            write_slot_limit(limit_settings[i]);
            run_traffic(35, (i % 3) != 1);
        end
    endtask

    // Long random run at the full table size.
    task automatic test_random_traffic();
        write_slot_limit(MAX_STATIONS_RESET);
        run_traffic(120, 1'b1);
        run_traffic(60, 1'b0);
    endtask

    // Drain outstanding answers and report.
    task automatic finish_run();
        hold_off(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    endtask

    // Reset, then run each test in turn.
    initial
    begin
        rst_n              = 1'b0;
        start              = 1'b0;
        max_stations_we    = 1'b0;
        max_stations_wdata = '0;
        req_kind           = KIND_ADD;
        req_mac            = '0;
        req_ip             = '0;
        req_time           = '0;
        error_count        = 0;
        idle_cycles        = 0;
        shadow_count       = '0;
        shadow_limit       = MAX_STATIONS_RESET;
        foreach (shadow_mac[i])
            shadow_mac[i] = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_rejected_requests();
        test_table_fill();
        test_slot_limit_sweep();
        test_random_traffic();
        finish_run();
    end

endmodule
